FILE: hw/rtl/dnsle_pkg.sv
// ----------------------------------------------------------------------------
// dnsle_pkg
// Shared constants and types for the DNS name label encoder.
// ----------------------------------------------------------------------------
package dnsle_pkg;

  // Default label bound and the fixed width of a label store address.
  localparam int unsigned LabelMax = 62;
  localparam int unsigned AddrW    = 6;

  localparam logic       OpChar   = 1'b0;
  localparam logic       OpEnd    = 1'b1;
  localparam logic [7:0] DotChar  = 8'h2E;
  localparam logic [7:0] TermByte = 8'h00;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } wr_req_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
  } rd_req_t;

endpackage

FILE: hw/rtl/dnsle_label_mem.sv
// ----------------------------------------------------------------------------
// dnsle_label_mem
// Label byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dnsle_label_mem #(
  parameter int unsigned LABEL_MAX = dnsle_pkg::LabelMax
) (
  input  logic              clk_i,
  input  dnsle_pkg::wr_req_t wr_i,
  input  dnsle_pkg::rd_req_t rd_i,
  output logic [7:0]        rdata_o
);

  localparam int unsigned IdxW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

  logic [7:0] mem [LABEL_MAX];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr[IdxW-1:0]] <= wr_i.data;
    end
  end

  // read data holds until the next read is issued
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr[IdxW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/dns_name_label_encoder.sv
// ----------------------------------------------------------------------------
// dns_name_label_encoder
// Buffers host name characters per label and replays each label in DNS wire
// form: length byte, label bytes, and a zero terminator at end of name.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------
//  in       | in_valid_i / in_stall_o  | operation_i, character_i
//  out      | out_valid_o / out_stall_i| out_byte_o, last_o, overflow_o
//
//  A name character is one store write; past the label bound it only sets
//  the overflow flag. A dot or end item is accepted, then the length byte is
//  sent; for a nonempty label the store reads are issued (registered read
//  data) and each buffered byte is sent, followed by the terminator on an
//  end item.
//  Input stalls for the whole replay; output stalls pause the replay.
//  Reset clears the label length, overflow flag and control; the store is
//  not cleared.
// ----------------------------------------------------------------------------
module dns_name_label_encoder #(
  parameter int unsigned LABEL_MAX = dnsle_pkg::LabelMax
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  input  logic [7:0] character_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       overflow_o
);

  localparam int unsigned LenW = $clog2(LABEL_MAX + 1);

  typedef enum logic [1:0] {
    StIdle,
    StLen,
    StData,
    StTerm
  } state_e;

  state_e          state_q;
  logic [LenW-1:0] len_q;
  logic [LenW-1:0] rd_idx_q;
  logic [LenW-1:0] sent_q;
  logic            ovf_q;
  logic            term_q;
  logic            rd_pend_q;
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            last_q;
  logic            overflow_q;

  logic               in_acc;
  logic               out_free;
  logic               consume;
  logic               issue;
  logic               emit;
  logic               last_data;
  logic [7:0]         rdata;
  dnsle_pkg::wr_req_t wr_req;
  dnsle_pkg::rd_req_t rd_req;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign consume   = (state_q == StData) && rd_pend_q && out_free;
  assign issue     = (state_q == StData) && (rd_idx_q < len_q) && (!rd_pend_q || consume);
  assign last_data = (LenW'(sent_q + 1'b1) == len_q);
  // an output item is loaded this cycle
  assign emit      = ((state_q == StLen || state_q == StTerm) && out_free) || consume;

  always_comb begin
    wr_req.en   = in_acc && (operation_i == dnsle_pkg::OpChar)
                  && (character_i != dnsle_pkg::DotChar) && (len_q < LenW'(LABEL_MAX));
    wr_req.addr = dnsle_pkg::AddrW'(len_q);
    wr_req.data = character_i;
    rd_req.en   = issue;
    rd_req.addr = dnsle_pkg::AddrW'(rd_idx_q);
  end

  dnsle_label_mem #(
    .LABEL_MAX (LABEL_MAX)
  ) u_mem (
    .clk_i   (clk_i),
    .wr_i    (wr_req),
    .rd_i    (rd_req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      rd_idx_q    <= '0;
      sent_q      <= '0;
      ovf_q       <= 1'b0;
      term_q      <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      last_q      <= 1'b0;
      overflow_q  <= 1'b0;
    end else begin
      out_valid_q <= emit || (out_valid_q && out_stall_i);
      if (issue) begin
        rd_idx_q <= LenW'(rd_idx_q + 1'b1);
      end
      rd_pend_q <= issue || (rd_pend_q && !consume);

      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (operation_i == dnsle_pkg::OpEnd || character_i == dnsle_pkg::DotChar) begin
              term_q  <= (operation_i == dnsle_pkg::OpEnd);
              state_q <= StLen;
            end else if (len_q < LenW'(LABEL_MAX)) begin
              len_q <= LenW'(len_q + 1'b1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        StLen: begin
          if (out_free) begin
            out_byte_q  <= 8'(len_q);
            last_q      <= !term_q && (len_q == '0);
            overflow_q  <= ovf_q;
            rd_idx_q    <= '0;
            sent_q      <= '0;
            if (len_q == '0) begin
              ovf_q   <= 1'b0;
              state_q <= term_q ? StTerm : StIdle;
            end else begin
              state_q <= StData;
            end
          end
        end
        StData: begin
          if (consume) begin
            out_byte_q  <= rdata;
            last_q      <= !term_q && last_data;
            overflow_q  <= ovf_q;
            sent_q      <= LenW'(sent_q + 1'b1);
            if (last_data) begin
              len_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= term_q ? StTerm : StIdle;
            end
          end
        end
        StTerm: begin
          if (out_free) begin
            out_byte_q  <= dnsle_pkg::TermByte;
            last_q      <= 1'b1;
            overflow_q  <= 1'b0;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;
  assign overflow_o  = overflow_q;

endmodule

FILE: verif/dnsle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsle_checker
// Watches both channels of the DNS name label encoder, predicts the wire
// bytes of every accepted item and compares each output item in order.
// ----------------------------------------------------------------------------
module dnsle_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       operation_i,
  input  logic [7:0] character_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic       last_i,
  input  logic       overflow_i,
  output int         outstanding_o,
  output int         fail_count_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } wire_byte_t;

  wire_byte_t                  wire_bytes_q[$];
  logic [7:0]                  label_buf [dnsle_pkg::LabelMax];
  logic [dnsle_pkg::AddrW-1:0] label_len;
  logic                        label_trunc;
  int                          fails = 0;

  assign fail_count_o = fails;

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
    fails++;
  endtask

  // Replays the pending label: length byte, then its bytes.
  function automatic void flush_label(bit marks_last);
    wire_bytes_q.push_back('{data: 8'(label_len),
                             last: marks_last && (label_len == 0),
                             ovf: label_trunc});
    for (int i = 0; i < int'(label_len); i++) begin
      wire_bytes_q.push_back('{data: label_buf[i],
                               last: marks_last && (i == int'(label_len) - 1),
                               ovf: label_trunc});
    end
    label_len   = '0;
    label_trunc = 1'b0;
  endfunction

  function automatic void encode_item(logic op, logic [7:0] ch);
    if (op == dnsle_pkg::OpEnd) begin
      flush_label(1'b0);
      wire_bytes_q.push_back('{data: dnsle_pkg::TermByte, last: 1'b1, ovf: 1'b0});
    end else if (ch == dnsle_pkg::DotChar) begin
      flush_label(1'b1);
    end else if (label_len < dnsle_pkg::LabelMax) begin
      label_buf[label_len] = ch;
      label_len++;
    end else begin
      label_trunc = 1'b1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wire_byte_t want;
    if (!rst_ni) begin
      wire_bytes_q.delete();
      label_len     = '0;
      label_trunc   = 1'b0;
      outstanding_o <= 0;
    end else begin
      // retire before predicting: an item never answers in its own cycle
      if (out_valid_i && !out_stall_i) begin
        if (wire_bytes_q.size() == 0) begin
          report_mismatch("unexpected item", int'(out_byte_i), 0);
        end else begin
          want = wire_bytes_q.pop_front();
          if (out_byte_i !== want.data) begin
            report_mismatch("out_byte", int'(out_byte_i), int'(want.data));
          end
          if (last_i !== want.last) begin
            report_mismatch("last", int'(last_i), int'(want.last));
          end
          if (overflow_i !== want.ovf) begin
            report_mismatch("overflow", int'(overflow_i), int'(want.ovf));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        encode_item(operation_i, character_i);
      end
      outstanding_o <= wire_bytes_q.size();
    end
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives host names, dots, end items and noise into the label encoder with
// random idling on both sides; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WatchdogLimit = 2000;
  localparam int LongHold      = 400;
  localparam int NameItems     = 350;
  localparam int LabelMaxI     = int'(dnsle_pkg::LabelMax);

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic       operation_i = dnsle_pkg::OpChar;
  logic [7:0] character_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_o;
  logic       overflow_o;

  int pending;
  int fail_count;
  int items_sent    = 0;
  int idle_cycles   = 0;
  bit calm          = 1'b0;
  bit long_hold_req = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  dns_name_label_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .character_i (character_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .overflow_o  (overflow_o)
  );

  dnsle_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .operation_i   (operation_i),
    .character_i   (character_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_i    (out_byte_o),
    .last_i        (last_o),
    .overflow_i    (overflow_o),
    .outstanding_o (pending),
    .fail_count_o  (fail_count)
  );

  // Called right after a rising edge; returns at the edge that takes the item.
  task automatic send_item(logic op, logic [7:0] ch);
    bit took;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    character_i <= ch;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    items_sent++;
  endtask

  function automatic logic [7:0] rand_char();
    unique case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'($urandom_range(8'h30, 8'h39));
      default: return 8'($urandom_range(8'h61, 8'h7a));
    endcase
  endfunction

  task automatic send_letters(int count);
    for (int j = 0; j < count; j++) send_item(dnsle_pkg::OpChar, 8'($urandom_range(8'h61, 8'h7a)));
  endtask

  // Well-formed name; now and then a label runs near or past the length bound.
  task automatic send_name();
    int labels;
    int len;
    labels = $urandom_range(0, 4);
    for (int k = 0; k < labels; k++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_letters($urandom_range(58, 66));
      end else begin
        len = $urandom_range(0, 7);
        for (int j = 0; j < len; j++) send_item(dnsle_pkg::OpChar, rand_char());
      end
      if (k < labels - 1 || $urandom_range(0, 4) == 0) begin
        send_item(dnsle_pkg::OpChar, dnsle_pkg::DotChar);
      end
    end
    send_item(dnsle_pkg::OpEnd, 8'($urandom()));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Receiver side: random stall bursts, one long hold on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        out_stall_i   <= 1'b0;
        long_hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty name, with a character on the end item
    send_item(dnsle_pkg::OpEnd, 8'hFF);
    // www.x -> 3 w w w 1 x 0
    send_item(dnsle_pkg::OpChar, "w");
    send_item(dnsle_pkg::OpChar, "w");
    send_item(dnsle_pkg::OpChar, "w");
    send_item(dnsle_pkg::OpChar, dnsle_pkg::DotChar);
    send_item(dnsle_pkg::OpChar, "x");
    send_item(dnsle_pkg::OpEnd, 8'h00);
    // leading dot, double dot, name ending in a dot
    send_item(dnsle_pkg::OpChar, dnsle_pkg::DotChar);
    send_item(dnsle_pkg::OpChar, "a");
    send_item(dnsle_pkg::OpChar, dnsle_pkg::DotChar);
    send_item(dnsle_pkg::OpChar, dnsle_pkg::DotChar);
    send_item(dnsle_pkg::OpEnd, 8'h2E);
    // zero byte and all-ones byte as label data
    send_item(dnsle_pkg::OpChar, 8'h00);
    send_item(dnsle_pkg::OpChar, 8'hFF);
    send_item(dnsle_pkg::OpChar, 8'h7F);
    send_item(dnsle_pkg::OpChar, 8'h80);
    send_item(dnsle_pkg::OpEnd, 8'h55);

    wait_drained();

    // long output hold while a full label and a truncated one go in
    long_hold_req = 1'b1;
    send_letters(LabelMaxI);
    send_item(dnsle_pkg::OpChar, dnsle_pkg::DotChar);
    send_letters(LabelMaxI + 3);
    send_item(dnsle_pkg::OpEnd, 8'hAA);

    while (items_sent < NameItems) begin
      if (items_sent > NameItems - 60) calm = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5)) send_item(1'($urandom_range(0, 1)), 8'($urandom()));
      end else begin
        send_name();
      end
    end
    send_item(dnsle_pkg::OpEnd, 8'($urandom()));

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
